>>> design/swdh_pkg.sv
// swdh_pkg: shared types, codes and constants of the serial wire debug host engine
// no dependencies; imported by every module of the block, but not by its interfaces
package swdh_pkg;

  // line framing constants
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned HDR_BITS  = 7;
  localparam int unsigned TSEL_SKIP = 1 + 5;
  localparam logic [2:0] ACK_OK      = 3'b001;
  localparam logic [6:0] TSEL_HEADER = 7'h19;   // 0x99 with the park bit dropped
  localparam logic [2:0] TURN_MIN    = 3'd1;
  localparam logic [2:0] TURN_MAX    = 3'd4;

  // command codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TSEL  = 2'd2;
  localparam logic [1:0] OP_RAW   = 2'd3;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ACK_ERR = 2'd1;
  localparam logic [1:0] ST_PAR_ERR = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_REQ   = 4'd1,
    PH_PARK  = 4'd2,
    PH_ACK   = 4'd3,
    PH_TURNW = 4'd4,
    PH_WDATA = 4'd5,
    PH_WPAR  = 4'd6,
    PH_RDATA = 4'd7,
    PH_RPAR  = 4'd8,
    PH_TURNR = 4'd9,
    PH_TSKIP = 4'd10,
    PH_RAW   = 4'd11
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  bit_counter;
    logic [31:0] shift_word;
    logic [2:0]  ack_store;
    logic [1:0]  active_kind;
    logic        parity_accum;
    logic [6:0]  hdr_word;
  } eng_state_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  op_kind;
    logic [6:0]  request_bits;
    logic [31:0] write_data;
    logic [3:0]  target_instance;
    logic [5:0]  raw_count;
    logic        line_in;
  } cmd_word_t;

  typedef struct packed {
    logic        line_out;
    logic        line_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  ack_value;
    logic [31:0] read_data;
  } res_word_t;

  // turnaround length clamped to one..four periods
  function automatic logic [2:0] turn_len(input logic [2:0] cycles);
    logic [2:0] t;
    t = cycles;
    if (t < TURN_MIN) t = TURN_MIN;
    if (t > TURN_MAX) t = TURN_MAX;
    return t;
  endfunction

endpackage

>>> design/swdh_cmd_if.sv
// swdh_cmd_if: command and tick channel into the serial wire debug host engine
// depends on nothing; field widths follow swdh_pkg::cmd_word_t
interface swdh_cmd_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  op_kind;
  logic [6:0]  request_bits;
  logic [31:0] write_data;
  logic [3:0]  target_instance;
  logic [5:0]  raw_count;
  logic        line_in;

  modport source (
    output valid, req_type, op_kind, request_bits, write_data, target_instance,
           raw_count, line_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, op_kind, request_bits, write_data, target_instance,
           raw_count, line_in,
    output ready
  );
endinterface

>>> design/swdh_res_if.sv
// swdh_res_if: result channel out of the serial wire debug host engine
// depends on nothing; field widths follow swdh_pkg::res_word_t
interface swdh_res_if;
  logic        valid;
  logic        ready;
  logic        line_out;
  logic        line_drive;
  logic        clock_pulse;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [2:0]  ack_value;
  logic [31:0] read_data;

  modport source (
    output valid, line_out, line_drive, clock_pulse, busy_res, done_res, status,
           ack_value, read_data,
    input  ready
  );
  modport sink (
    input  valid, line_out, line_drive, clock_pulse, busy_res, done_res, status,
           ack_value, read_data,
    output ready
  );
endinterface

>>> design/swdh_step.sv
// swdh_step: next-state and result logic for one tick or command of the engine
// depends on swdh_pkg (state, command and result types, codes)
module swdh_step
  import swdh_pkg::*;
(
  input  eng_state_t cur,
  input  cmd_word_t  cmd,
  input  logic [2:0] turn_setting,
  output eng_state_t nxt,
  output res_word_t  res
);

  logic        finish;
  logic [2:0]  tlen;
  logic [5:0]  rlen;
  logic [5:0]  count_dec;
  logic [5:0]  rd_pos;
  logic [1:0]  ack_pos;
  logic [31:0] tsel_word;

  always_comb begin
    nxt       = cur;
    res       = '0;
    finish    = 1'b0;
    tlen      = turn_len(turn_setting);
    rlen      = (cmd.raw_count > 6'(WORD_BITS)) ? 6'(WORD_BITS) : cmd.raw_count;
    tsel_word = cmd.write_data | {cmd.target_instance, 28'd0};
    count_dec = (cur.bit_counter != 6'd0) ? cur.bit_counter - 6'd1 : 6'd0;
    rd_pos    = 6'(WORD_BITS) - cur.bit_counter;
    ack_pos   = 2'd3 - cur.bit_counter[1:0];

    if (cmd.req_type == REQ_START) begin
      if (cur.phase != PH_IDLE) begin
        // busy: refuse, running command untouched
        res.busy_res = 1'b1;
        res.status   = ST_REFUSED;
      end else begin
        // start a new command
        nxt.active_kind  = cmd.op_kind;
        nxt.ack_store    = '0;
        nxt.parity_accum = 1'b0;
        nxt.shift_word   = '0;
        res.busy_res     = 1'b1;
        case (cmd.op_kind)
          OP_WRITE: begin
            nxt.hdr_word     = cmd.request_bits;
            nxt.shift_word   = cmd.write_data;
            nxt.parity_accum = ^cmd.write_data;
            nxt.phase        = PH_REQ;
            nxt.bit_counter  = 6'(HDR_BITS);
          end
          OP_READ: begin
            nxt.hdr_word    = cmd.request_bits;
            nxt.phase       = PH_REQ;
            nxt.bit_counter = 6'(HDR_BITS);
          end
          OP_TSEL: begin
            nxt.hdr_word     = TSEL_HEADER;
            nxt.shift_word   = tsel_word;
            nxt.parity_accum = ^tsel_word;
            nxt.phase        = PH_REQ;
            nxt.bit_counter  = 6'(HDR_BITS);
          end
          default: begin
            nxt.shift_word = cmd.write_data;
            if (rlen == 6'd0) begin
              // empty raw sequence finishes at once
              nxt.phase       = PH_IDLE;
              nxt.bit_counter = 6'd0;
              res.busy_res    = 1'b0;
              res.done_res    = 1'b1;
            end else begin
              nxt.phase       = PH_RAW;
              nxt.bit_counter = rlen;
            end
          end
        endcase
      end
    end else if (cur.phase != PH_IDLE) begin
      res.clock_pulse = 1'b1;

      // line activity of this period
      case (cur.phase)
        PH_REQ: begin
          res.line_drive = 1'b1;
          res.line_out   = cur.hdr_word[0];
          nxt.hdr_word   = cur.hdr_word >> 1;
        end
        PH_ACK: begin
          nxt.ack_store[ack_pos] = cur.ack_store[ack_pos] | cmd.line_in;
        end
        PH_WDATA, PH_RAW: begin
          res.line_drive = 1'b1;
          res.line_out   = cur.shift_word[0];
          nxt.shift_word = cur.shift_word >> 1;
        end
        PH_WPAR: begin
          res.line_drive = 1'b1;
          res.line_out   = cur.parity_accum;
        end
        PH_RDATA: begin
          nxt.shift_word[rd_pos[4:0]] = cur.shift_word[rd_pos[4:0]] | cmd.line_in;
          nxt.parity_accum            = cur.parity_accum ^ cmd.line_in;
        end
        PH_RPAR: begin
          nxt.parity_accum = cur.parity_accum ^ cmd.line_in;
        end
        default: begin
        end
      endcase

      nxt.bit_counter = count_dec;

      // phase change when the count runs out
      if (count_dec == 6'd0) begin
        case (cur.phase)
          PH_REQ: begin
            if (cur.active_kind == OP_TSEL) begin
              nxt.phase       = PH_TSKIP;
              nxt.bit_counter = 6'(TSEL_SKIP);
            end else begin
              nxt.phase       = PH_PARK;
              nxt.bit_counter = 6'(tlen) + 6'd1;
            end
          end
          PH_PARK: begin
            nxt.phase       = PH_ACK;
            nxt.bit_counter = 6'd3;
          end
          PH_ACK: begin
            if (cur.active_kind == OP_WRITE) begin
              nxt.phase       = PH_TURNW;
              nxt.bit_counter = 6'(tlen);
            end else if (nxt.ack_store != ACK_OK) begin
              nxt.phase       = PH_TURNR;
              nxt.bit_counter = 6'(tlen);
            end else begin
              nxt.shift_word   = '0;
              nxt.parity_accum = 1'b0;
              nxt.phase        = PH_RDATA;
              nxt.bit_counter  = 6'(WORD_BITS);
            end
          end
          PH_TURNW: begin
            if (cur.ack_store == ACK_OK) begin
              nxt.phase       = PH_WDATA;
              nxt.bit_counter = 6'(WORD_BITS);
            end else begin
              res.status = ST_ACK_ERR;
              finish     = 1'b1;
            end
          end
          PH_TSKIP: begin
            nxt.phase       = PH_WDATA;
            nxt.bit_counter = 6'(WORD_BITS);
          end
          PH_WDATA: begin
            nxt.phase       = PH_WPAR;
            nxt.bit_counter = 6'd1;
          end
          PH_RDATA: begin
            nxt.phase       = PH_RPAR;
            nxt.bit_counter = 6'd1;
          end
          PH_RPAR: begin
            nxt.phase       = PH_TURNR;
            nxt.bit_counter = 6'(tlen);
          end
          PH_TURNR: begin
            if (cur.ack_store != ACK_OK) res.status = ST_ACK_ERR;
            else if (cur.parity_accum) res.status = ST_PAR_ERR;
            else res.read_data = cur.shift_word;
            finish = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      // completion of the command
      if (finish) begin
        if (cur.active_kind == OP_WRITE || cur.active_kind == OP_READ) begin
          res.ack_value = nxt.ack_store;
        end
        nxt.phase       = PH_IDLE;
        nxt.bit_counter = 6'd0;
        res.done_res    = 1'b1;
      end else begin
        res.busy_res = 1'b1;
      end
    end
  end

endmodule

>>> design/swd_host_transaction_engine.sv
// Serial wire debug host transaction engine. Every word on the cmd channel is one
// serial clock period (a tick carrying the sampled line level) or the start of a
// write, read, target select or raw sequence, and it yields exactly one result word
// giving the level to drive, the drive enable, whether a clock period was issued and
// the command status. The engine takes one word per clock cycle: the phase state is
// updated in the same cycle a word is accepted, and the only thing that holds off
// the next word is the single result register, which must be free or being taken.
// The turnaround length register may be written only while no command is running.
// depends on swdh_pkg, swdh_cmd_if, swdh_res_if and swdh_step
module swd_host_transaction_engine
  import swdh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  swdh_cmd_if.sink   cmd,
  swdh_res_if.source res
);

  eng_state_t state;
  eng_state_t state_next;
  res_word_t  res_word;
  res_word_t  res_word_next;
  cmd_word_t  cmd_word;
  logic [2:0] turn_setting;
  logic       out_valid;
  logic       in_accept;

  // input handshake: take a word whenever the result register can be loaded
  assign cmd.ready = !out_valid || res.ready;
  assign in_accept = cmd.valid && cmd.ready;

  assign cmd_word.req_type        = cmd.req_type;
  assign cmd_word.op_kind         = cmd.op_kind;
  assign cmd_word.request_bits    = cmd.request_bits;
  assign cmd_word.write_data      = cmd.write_data;
  assign cmd_word.target_instance = cmd.target_instance;
  assign cmd_word.raw_count       = cmd.raw_count;
  assign cmd_word.line_in         = cmd.line_in;

  // per-word phase logic
  swdh_step u_step (
    .cur          (state),
    .cmd          (cmd_word),
    .turn_setting (turn_setting),
    .nxt          (state_next),
    .res          (res_word_next)
  );

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      turn_setting <= TURN_MIN;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) turn_setting <= cfg_wr_data;
      if (in_accept) begin
        state     <= state_next;
        res_word  <= res_word_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result channel
  assign res.valid       = out_valid;
  assign res.line_out    = res_word.line_out;
  assign res.line_drive  = res_word.line_drive;
  assign res.clock_pulse = res_word.clock_pulse;
  assign res.busy_res    = res_word.busy_res;
  assign res.done_res    = res_word.done_res;
  assign res.status      = res_word.status;
  assign res.ack_value   = res_word.ack_value;
  assign res.read_data   = res_word.read_data;

  // a start while a command runs is refused in the next result
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd.req_type == REQ_START && state.phase != PH_IDLE)
      |=> (res.valid && res.status == ST_REFUSED && res.busy_res))
    else $error("busy start not refused");

  // a tick while idle gives no clock and no drive
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd.req_type == REQ_TICK && state.phase == PH_IDLE)
      |=> (!res.clock_pulse && !res.line_drive && !res.busy_res))
    else $error("idle tick produced activity");

  // the host only drives in a clocked period
  a_drive_clk: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.line_drive) |-> res.clock_pulse)
    else $error("line driven without a clock period");

  // done and busy are exclusive
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.done_res && res.busy_res))
    else $error("done and busy both set");

  // idle always leaves the bit counter cleared
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_IDLE) |-> (state.bit_counter == 6'd0))
    else $error("bit counter left running in idle");

endmodule

>>> tb/swdh_line_checker.sv
`timescale 1ns / 100ps
// swdh_line_checker: watches the command and result channels of the swd host engine,
// keeps its own copy of the engine state and compares every result word in order
// depends on swdh_pkg (types, codes, framing constants), swdh_cmd_if and swdh_res_if
module swdh_line_checker
  import swdh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  swdh_cmd_if        cmd,
  swdh_res_if        res,
  output int         fail_count,
  output int         awaiting
);

  // engine state as this checker sees it
  phase_t      eng_phase;
  logic [5:0]  bits_left;
  logic [31:0] data_sr;
  logic [2:0]  ack_bits;
  logic [1:0]  cur_op;
  logic        par_bit;
  logic [6:0]  hdr_sr;
  logic [2:0]  turn_setting;

  // result words still owed by the engine, oldest first
  res_word_t   owed_words[$];

  // turnaround periods, clamped to one..four
  function automatic logic [5:0] turn_periods();
    logic [5:0] t;
    t = {3'd0, turn_setting};
    if (t < 6'd1) t = 6'd1;
    if (t > 6'd4) t = 6'd4;
    return t;
  endfunction

  function automatic void enter_phase(input phase_t p, input logic [5:0] n);
    eng_phase = p;
    bits_left = n;
  endfunction

  // one command or tick word in, one result word out
  function automatic res_word_t step_engine(input cmd_word_t w);
    res_word_t  r;
    logic       fin;
    logic [5:0] n;
    logic [4:0] pos;
    logic [1:0] apos;
    r   = '0;
    fin = 1'b0;
    if (w.req_type == REQ_START) begin
      r.busy_res = 1'b1;
      if (eng_phase != PH_IDLE) begin
        // refused, running command untouched
        r.status = ST_REFUSED;
      end else begin
        cur_op   = w.op_kind;
        ack_bits = '0;
        par_bit  = 1'b0;
        data_sr  = '0;
        case (w.op_kind)
          OP_WRITE: begin
            hdr_sr  = w.request_bits;
            data_sr = w.write_data;
            par_bit = ^w.write_data;
            enter_phase(PH_REQ, 6'(HDR_BITS));
          end
          OP_READ: begin
            hdr_sr = w.request_bits;
            enter_phase(PH_REQ, 6'(HDR_BITS));
          end
          OP_TSEL: begin
            hdr_sr  = TSEL_HEADER;
            data_sr = w.write_data | {w.target_instance, 28'd0};
            par_bit = ^data_sr;
            enter_phase(PH_REQ, 6'(HDR_BITS));
          end
          default: begin
            n       = (w.raw_count > 6'(WORD_BITS)) ? 6'(WORD_BITS) : w.raw_count;
            data_sr = w.write_data;
            if (n == 6'd0) begin
              // empty raw sequence finishes at once
              eng_phase  = PH_IDLE;
              bits_left  = '0;
              r.busy_res = 1'b0;
              r.done_res = 1'b1;
            end else begin
              enter_phase(PH_RAW, n);
            end
          end
        endcase
      end
    end else if (eng_phase != PH_IDLE) begin
      r.clock_pulse = 1'b1;
      // line activity of this period
      case (eng_phase)
        PH_REQ: begin
          r.line_drive = 1'b1;
          r.line_out   = hdr_sr[0];
          hdr_sr       = hdr_sr >> 1;
        end
        PH_ACK: begin
          apos           = 2'(6'd3 - bits_left);
          ack_bits[apos] = ack_bits[apos] | w.line_in;
        end
        PH_WDATA, PH_RAW: begin
          r.line_drive = 1'b1;
          r.line_out   = data_sr[0];
          data_sr      = data_sr >> 1;
        end
        PH_WPAR: begin
          r.line_drive = 1'b1;
          r.line_out   = par_bit;
        end
        PH_RDATA: begin
          pos          = 5'(6'd32 - bits_left);
          data_sr[pos] = data_sr[pos] | w.line_in;
          par_bit      = par_bit ^ w.line_in;
        end
        PH_RPAR: par_bit = par_bit ^ w.line_in;
        default: ;
      endcase
      if (bits_left != 6'd0) bits_left = bits_left - 6'd1;
      // phase change once the period count runs out
      if (bits_left == 6'd0) begin
        case (eng_phase)
          PH_REQ: begin
            if (cur_op == OP_TSEL) enter_phase(PH_TSKIP, 6'(TSEL_SKIP));
            else enter_phase(PH_PARK, 6'd1 + turn_periods());
          end
          PH_PARK: enter_phase(PH_ACK, 6'd3);
          PH_ACK: begin
            if (cur_op == OP_WRITE) begin
              enter_phase(PH_TURNW, turn_periods());
            end else if (ack_bits != ACK_OK) begin
              enter_phase(PH_TURNR, turn_periods());
            end else begin
              data_sr = '0;
              par_bit = 1'b0;
              enter_phase(PH_RDATA, 6'(WORD_BITS));
            end
          end
          PH_TURNW: begin
            if (ack_bits == ACK_OK) begin
              enter_phase(PH_WDATA, 6'(WORD_BITS));
            end else begin
              r.status = ST_ACK_ERR;
              fin      = 1'b1;
            end
          end
          PH_TSKIP: enter_phase(PH_WDATA, 6'(WORD_BITS));
          PH_WDATA: enter_phase(PH_WPAR, 6'd1);
          PH_RDATA: enter_phase(PH_RPAR, 6'd1);
          PH_RPAR:  enter_phase(PH_TURNR, turn_periods());
          PH_TURNR: begin
            if (ack_bits != ACK_OK) r.status = ST_ACK_ERR;
            else if (par_bit) r.status = ST_PAR_ERR;
            else r.read_data = data_sr;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      if (fin) begin
        if (cur_op == OP_WRITE || cur_op == OP_READ) r.ack_value = ack_bits;
        eng_phase  = PH_IDLE;
        bits_left  = '0;
        r.done_res = 1'b1;
      end else begin
        r.busy_res = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // sample both channels at each rising edge
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    cmd_word_t w;
    if (rst) begin
      eng_phase    = PH_IDLE;
      bits_left    = '0;
      data_sr      = '0;
      ack_bits     = '0;
      cur_op       = OP_WRITE;
      par_bit      = 1'b0;
      hdr_sr       = '0;
      turn_setting = TURN_MIN;
      owed_words.delete();
    end else begin
      // result side first: a word taken now was never caused by this edge's input
      if (res.valid && res.ready) begin
        got = {res.line_out, res.line_drive, res.clock_pulse, res.busy_res,
               res.done_res, res.status, res.ack_value, res.read_data};
        if (owed_words.size() == 0) begin
          fail_count++;
          $display("%0t mismatch: expected no result word, actual %h", $time, got);
        end else begin
          want = owed_words.pop_front();
          check_field("line_out", 32'(want.line_out), 32'(got.line_out));
          check_field("line_drive", 32'(want.line_drive), 32'(got.line_drive));
          check_field("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("ack_value", 32'(want.ack_value), 32'(got.ack_value));
          check_field("read_data", want.read_data, got.read_data);
        end
      end
      if (cmd.valid && cmd.ready) begin
        w = {cmd.req_type, cmd.op_kind, cmd.request_bits, cmd.write_data,
             cmd.target_instance, cmd.raw_count, cmd.line_in};
        owed_words.push_back(step_engine(w));
      end
      if (cfg_wr_en) turn_setting = cfg_wr_data;
    end
    awaiting <= owed_words.size();
  end

endmodule

>>> tb/tb_swd_host_transaction_engine.sv
`timescale 1ns / 100ps
// tb_swd_host_transaction_engine: drives register, target select and raw commands
// with their serial periods into the swd host engine and gives the verdict
// depends on swdh_pkg, swdh_cmd_if, swdh_res_if, swdh_line_checker and the engine
module tb_swd_host_transaction_engine;
  import swdh_pkg::*;

  localparam int ITEM_TARGET    = 950;
  localparam int STALL_LIMIT    = 4000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  int         fail_count;
  int         awaiting;
  int         items_sent;
  int         quiet_cycles;
  int         turn_now;
  bit         no_gaps;
  bit         squeeze_go;

  swdh_cmd_if cmd_ch ();
  swdh_res_if res_ch ();

  swd_host_transaction_engine DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch)
  );

  swdh_line_checker line_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .awaiting    (awaiting)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.req_type        = REQ_TICK;
    w.op_kind         = 2'($urandom);
    w.request_bits    = 7'($urandom);
    w.write_data      = $urandom;
    w.target_instance = 4'($urandom);
    w.raw_count       = 6'($urandom);
    w.line_in         = 1'($urandom);
    return w;
  endfunction

  // offer one word and hold it until taken
  task automatic put_word(input cmd_word_t w);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.req_type        <= w.req_type;
    cmd_ch.op_kind         <= w.op_kind;
    cmd_ch.request_bits    <= w.request_bits;
    cmd_ch.write_data      <= w.write_data;
    cmd_ch.target_instance <= w.target_instance;
    cmd_ch.raw_count       <= w.raw_count;
    cmd_ch.line_in         <= w.line_in;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  // one serial period, sometimes preceded by a command that must be refused
  task automatic tick(input logic lin, input int refuse_pct);
    cmd_word_t w;
    w = random_word();
    if ($urandom_range(0, 99) < refuse_pct) begin
      w.req_type = REQ_START;
      put_word(w);
      w = random_word();
    end
    w.req_type = REQ_TICK;
    w.line_in  = lin;
    put_word(w);
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) tick(1'($urandom), 0);
  endtask

  // turnaround register, written only once every result is in
  task automatic set_turn(input logic [2:0] v);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    turn_now = (v < TURN_MIN) ? TURN_MIN : (v > TURN_MAX) ? TURN_MAX : v;
  endtask

  // a whole command: start word, then the periods it needs, playing the target side
  task automatic run_command(input logic [1:0] op, input logic [6:0] hdr,
                             input logic [31:0] data, input logic [3:0] inst,
                             input logic [5:0] cnt, input logic [2:0] ack,
                             input bit flip, input int refuse_pct);
    cmd_word_t w;
    int        n;
    w                 = random_word();
    w.req_type        = REQ_START;
    w.op_kind         = op;
    w.request_bits    = hdr;
    w.write_data      = data;
    w.target_instance = inst;
    w.raw_count       = cnt;
    put_word(w);
    case (op)
      OP_WRITE, OP_READ: begin
        // header, park and turnaround, then the ack from the target
        repeat (HDR_BITS + 1 + turn_now) tick(1'($urandom), refuse_pct);
        for (int i = 0; i < 3; i++) tick(ack[i], refuse_pct);
        if (op == OP_WRITE) begin
          repeat (turn_now) tick(1'($urandom), refuse_pct);
          if (ack == ACK_OK) repeat (WORD_BITS + 1) tick(1'($urandom), refuse_pct);
        end else begin
          if (ack == ACK_OK) begin
            for (int i = 0; i < WORD_BITS; i++) tick(data[i], refuse_pct);
            tick((^data) ^ flip, refuse_pct);
          end
          repeat (turn_now) tick(1'($urandom), refuse_pct);
        end
      end
      OP_TSEL: begin
        repeat (HDR_BITS + TSEL_SKIP + WORD_BITS + 1) tick(1'($urandom), refuse_pct);
      end
      default: begin
        n = (cnt > WORD_BITS) ? WORD_BITS : cnt;
        repeat (n) tick(1'($urandom), refuse_pct);
      end
    endcase
  endtask

  // result side: random stalls, plus one long hold while the sender keeps offering
  initial begin
    int  hold;
    int  run;
    bit  squeezed;
    hold     = 0;
    run      = 0;
    squeezed = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_go && !squeezed) begin
        squeezed = 1'b1;
        hold     = SQUEEZE_CYCLES;
      end
      if (hold == 0 && run == 0) begin
        hold = gap_len();
        run  = $urandom_range(1, 16);
      end
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        run--;
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int          phase_left;
    int          r;
    int          refuse_pct;
    logic [1:0]  op;
    logic [2:0]  ack;
    logic [5:0]  cnt;
    rst                    <= 1'b1;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    cmd_ch.valid           <= 1'b0;
    cmd_ch.req_type        <= REQ_TICK;
    cmd_ch.op_kind         <= OP_WRITE;
    cmd_ch.request_bits    <= '0;
    cmd_ch.write_data      <= '0;
    cmd_ch.target_instance <= '0;
    cmd_ch.raw_count       <= '0;
    cmd_ch.line_in         <= 1'b0;
    squeeze_go             <= 1'b0;
    no_gaps    = 1'b0;
    items_sent = 0;
    turn_now   = TURN_MIN;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: idle periods, each command kind, ack and parity failures
    idle_ticks(2);
    set_turn(3'd0);
    run_command(OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 4'hF, 6'd63, ACK_OK, 1'b0, 0);
    run_command(OP_WRITE, 7'h00, 32'h0000_0000, 4'h0, 6'd0, 3'b010, 1'b0, 0);
    set_turn(3'd7);
    run_command(OP_READ, 7'h5A, 32'hFFFF_FFFF, 4'h0, 6'd1, ACK_OK, 1'b0, 0);
    run_command(OP_READ, 7'h25, 32'h0000_0000, 4'h5, 6'd2, ACK_OK, 1'b1, 0);
    run_command(OP_READ, 7'h7F, 32'h1234_5678, 4'hA, 6'd3, 3'b100, 1'b0, 0);
    set_turn(3'd4);
    run_command(OP_WRITE, 7'h33, 32'hA5A5_5A5A, 4'h3, 6'd4, 3'b111, 1'b0, 0);
    run_command(OP_TSEL, 7'h00, 32'h0000_0000, 4'hF, 6'd5, ACK_OK, 1'b0, 0);
    run_command(OP_TSEL, 7'h7F, 32'hFFFF_FFFF, 4'h0, 6'd6, ACK_OK, 1'b0, 0);
    run_command(OP_RAW, 7'h11, 32'hDEAD_BEEF, 4'h1, 6'd0, ACK_OK, 1'b0, 0);
    run_command(OP_RAW, 7'h22, 32'hFFFF_FFFF, 4'h2, 6'd1, ACK_OK, 1'b0, 0);
    run_command(OP_RAW, 7'h44, 32'h8000_0001, 4'h4, 6'd32, ACK_OK, 1'b0, 0);
    run_command(OP_RAW, 7'h08, 32'h0F0F_F0F0, 4'h8, 6'd63, ACK_OK, 1'b0, 0);
    run_command(OP_RAW, 7'h01, 32'h0000_0003, 4'h6, 6'd2, ACK_OK, 1'b0, 100);
    idle_ticks(2);

    // random: mostly well-formed commands, with refusals, bad acks and bad parity
    phase_left = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_left == 0) begin
        set_turn(3'($urandom_range(0, 7)));
        phase_left = $urandom_range(3, 8);
        no_gaps    = ($urandom_range(0, 3) == 0);
        squeeze_go <= 1'b1;
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_WRITE;
      else if (r < 60) op = OP_READ;
      else if (r < 75) op = OP_TSEL;
      else op = OP_RAW;
      ack = ($urandom_range(0, 9) < 8) ? ACK_OK : 3'($urandom);
      r   = $urandom_range(0, 99);
      if (r < 8) cnt = 6'd0;
      else if (r < 20) cnt = 6'($urandom_range(33, 63));
      else cnt = 6'($urandom_range(1, 32));
      refuse_pct = ($urandom_range(0, 4) == 0) ? 3 : 0;
      run_command(op, 7'($urandom), $urandom, 4'($urandom), cnt, ack,
                  ($urandom_range(0, 6) == 0), refuse_pct);
      if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 3));
    end

    // drain and verdict
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
